// ----- hw/rtl/wstm_pkg.sv -----
// Package of the whitespace-skipping text matcher: item and config types,
// character codes, queue depths and the case fold function. No dependencies.
package wstm_pkg;

   localparam int MAX_QUERY_DEF   = 16;
   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int TOTAL_BITS      = 16;
   localparam int IN_DEPTH        = 4;
   localparam int OUT_DEPTH       = 2;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      CSR_QUERY_LOW  = 2'd0,
      CSR_QUERY_HIGH = 2'd1,
      CSR_QUERY_LEN  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_TEXT    = 2'd0,
      CLS_BLANK   = 2'd1,
      CLS_NEWLINE = 2'd2,
      CLS_END     = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] ch;   // folded to lower case
   } item_type;

   typedef struct packed {
      logic [63:0] chars_low;
      logic [63:0] chars_high;
      logic [4:0]  length;
   } cfg_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_NEWLINE) || (c == CHAR_TAB) || (c == CHAR_SPACE);
   endfunction

endpackage

// ----- hw/rtl/wstm_queue.sv -----
// Small register FIFO used on both sides of the matcher.
// Depends on nothing; width and depth come from the instantiating module.
module wstm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/wstm_front.sv -----
// Front end of the matcher: classifies each incoming byte and folds its case.
// Depends on wstm_pkg.
module wstm_front (
   input  logic              [7:0] text_byte,
   input  logic                    end_marker,
   output wstm_pkg::item_type      item
);

   always_comb begin
      item.ch = wstm_pkg::fold(text_byte);
      priority if (end_marker) begin
         item.cls = wstm_pkg::CLS_END;
      end else if (text_byte == wstm_pkg::CHAR_NEWLINE) begin
         item.cls = wstm_pkg::CLS_NEWLINE;
      end else if (wstm_pkg::is_blank(text_byte)) begin
         item.cls = wstm_pkg::CLS_BLANK;
      end else begin
         item.cls = wstm_pkg::CLS_TEXT;
      end
   end

endmodule

// ----- hw/rtl/wstm_back.sv -----
// Back end of the matcher: position counters, window of recent text bytes,
// parallel query compare and result build. Depends on wstm_pkg.
module wstm_back #(
   parameter int MAX_QUERY   = wstm_pkg::MAX_QUERY_DEF,
   parameter int LINE_BITS   = wstm_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = wstm_pkg::COLUMN_BITS_DEF,
   localparam int RES_W      = 1 + LINE_BITS + COLUMN_BITS + wstm_pkg::TOTAL_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wstm_pkg::cfg_type    cfg,
   input  wstm_pkg::item_type   item,
   input  logic                 item_valid,
   output logic                 item_pop,
   input  logic                 res_full,
   output logic                 res_push,
   output logic [RES_W-1:0]     res_data
);

   localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int LEN_W = $clog2(MAX_QUERY + 1);
   localparam int TB    = wstm_pkg::TOTAL_BITS;

   logic [7:0]             win_char_ff [MAX_QUERY];
   logic [LINE_BITS-1:0]   win_line_ff [MAX_QUERY];
   logic [COLUMN_BITS-1:0] win_col_ff  [MAX_QUERY];
   logic [LEN_W-1:0]       depth_ff, depth_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [TB-1:0]          total_ff, total_in;

   logic [7:0]             nxt_char [MAX_QUERY];
   logic [LINE_BITS-1:0]   nxt_line [MAX_QUERY];
   logic [COLUMN_BITS-1:0] nxt_col  [MAX_QUERY];
   logic [7:0]             qfold    [MAX_QUERY];
   logic [127:0]           qall;
   logic [LEN_W-1:0]       len;
   logic [LEN_W-1:0]       depth_inc;
   logic [IDX_W-1:0]       start_idx;
   logic                   take, shift, hit;
   logic [LINE_BITS-1:0]   line_inc;
   logic [COLUMN_BITS-1:0] col_inc;

   assign take     = item_valid && !res_full;
   assign item_pop = take;
   assign shift    = take && (item.cls == wstm_pkg::CLS_TEXT);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
   assign col_inc  = (col_ff == '1) ? col_ff : col_ff + COLUMN_BITS'(1);
   assign qall     = {cfg.chars_high, cfg.chars_low};

   // window fill once a text byte goes in, saturating at the window size
   assign depth_inc = (depth_ff == LEN_W'(MAX_QUERY)) ? depth_ff : depth_ff + LEN_W'(1);

   // effective query length, clamped to the window size
   assign len = (cfg.length > 5'(MAX_QUERY)) ? LEN_W'(MAX_QUERY) : LEN_W'(cfg.length);
   assign start_idx = IDX_W'(len - LEN_W'(1));

   // window as it stands after the incoming byte is shifted in
   always_comb begin
      for (int j = 0; j < MAX_QUERY; j++) begin
         if (j == 0) begin
            nxt_char[j] = item.ch;
            nxt_line[j] = line_ff;
            nxt_col[j]  = col_ff;
         end else begin
            nxt_char[j] = win_char_ff[j-1];
            nxt_line[j] = win_line_ff[j-1];
            nxt_col[j]  = win_col_ff[j-1];
         end
         qfold[j] = wstm_pkg::fold(qall[8*j +: 8]);
      end
   end

   // entry j (newest first) must equal query character len-1-j
   always_comb begin
      logic [IDX_W-1:0] qi;
      hit = (len != '0) && (depth_inc >= len) && !wstm_pkg::is_blank(qall[7:0]);
      for (int j = 0; j < MAX_QUERY; j++) begin
         qi = IDX_W'(len - LEN_W'(1) - LEN_W'(j));
         if (LEN_W'(j) < len && nxt_char[j] != qfold[qi]) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      depth_in = depth_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      total_in = total_ff;
      res_push = 1'b0;
      res_data = '0;
      if (shift) begin
         depth_in = depth_inc;
      end
      if (take) begin
         unique case (item.cls)
            wstm_pkg::CLS_END: begin
               res_push = 1'b1;
               res_data = {1'b1, line_ff, COLUMN_BITS'(0), total_ff};
               depth_in = '0;
               line_in  = '0;
               col_in   = COLUMN_BITS'(1);
               total_in = '0;
            end
            wstm_pkg::CLS_NEWLINE: begin
               line_in = line_inc;
               col_in  = COLUMN_BITS'(1);
            end
            wstm_pkg::CLS_BLANK: begin
               col_in = col_inc;
            end
            wstm_pkg::CLS_TEXT: begin
               col_in = col_inc;
               if (hit) begin
                  total_in = (total_ff == '1) ? total_ff : total_ff + TB'(1);
                  res_push = 1'b1;
                  res_data = {1'b0, nxt_line[start_idx], nxt_col[start_idx], total_in};
               end
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         line_ff  <= '0;
         col_ff   <= COLUMN_BITS'(1);
         total_ff <= '0;
      end else begin
         depth_ff <= depth_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         for (int j = 0; j < MAX_QUERY; j++) begin
            win_char_ff[j] <= nxt_char[j];
            win_line_ff[j] <= nxt_line[j];
            win_col_ff[j]  <= nxt_col[j];
         end
      end
   end

endmodule

// ----- hw/rtl/whitespace_skipping_text_matcher.sv -----
// Top level of the whitespace-skipping text matcher: config registers,
// input and result queues around the front and back ends. Uses wstm_pkg.
//
// Usage: text bytes go in on the req_ queue (push while full is low), one
// item per byte; an item with req_end_marker set closes the file. Results
// come out of the rsp_ queue (pop while empty is low): kind 0 is a match
// with the line (from 0) and column (from 1) of its first byte, kind 1 is the
// end-of-file summary with the newline count and the number of matches.
// Blank bytes (space, tab, newline) are skipped inside a match; case is
// ignored for A-Z only. Counters saturate.
// A result is pushed into the result queue in the cycle in which the back end
// takes the item that causes it. Throughput: one item every cycle while the
// result queue is not full, set by the combinational window compare.
// The csr_ port is always ready; write it only while no items are in flight.
// Reset empties both queues, clears the counters and sets the query to
// length 1 with all characters zero. When the receiver stalls, the two-entry
// result queue fills, the back end stops, then the four-entry input queue
// fills and req_full rises.
module whitespace_skipping_text_matcher #(
   parameter int MAX_QUERY   = wstm_pkg::MAX_QUERY_DEF,
   parameter int LINE_BITS   = wstm_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = wstm_pkg::COLUMN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_marker,
   // result items
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_result_kind,
   output logic [LINE_BITS-1:0]   rsp_match_line,
   output logic [COLUMN_BITS-1:0] rsp_match_column,
   output logic [15:0]            rsp_occurrence_count,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_data
);

   localparam int ITEM_W = $bits(wstm_pkg::item_type);
   localparam int RES_W  = 1 + LINE_BITS + COLUMN_BITS + wstm_pkg::TOTAL_BITS;

   wstm_pkg::cfg_type  cfg_ff, cfg_in;
   wstm_pkg::item_type front_item, back_item;
   logic [ITEM_W-1:0]  in_head;
   logic               in_empty, back_pop;
   logic               res_full, res_push;
   logic [RES_W-1:0]   res_data, res_head;

   assign csr_ready = 1'b1;

   // register file: writes outside the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (wstm_pkg::csr_index_type'(csr_index))
            wstm_pkg::CSR_QUERY_LOW:  cfg_in.chars_low  = csr_data;
            wstm_pkg::CSR_QUERY_HIGH: cfg_in.chars_high = csr_data;
            wstm_pkg::CSR_QUERY_LEN:  cfg_in.length     = csr_data[4:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chars_low  <= '0;
         cfg_ff.chars_high <= '0;
         cfg_ff.length     <= 5'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and fold on the way into the input queue
   wstm_front u_front (
      .text_byte  (req_text_byte),
      .end_marker (req_end_marker),
      .item       (front_item)
   );

   wstm_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (wstm_pkg::IN_DEPTH)
   ) u_in_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (back_pop),
      .rd_data (in_head),
      .empty   (in_empty)
   );

   assign back_item = in_head;

   // back: window, counters and compare
   wstm_back #(
      .MAX_QUERY   (MAX_QUERY),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (back_item),
      .item_valid (!in_empty),
      .item_pop   (back_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // result queue decouples the back end from the receiver
   wstm_queue #(
      .WIDTH (RES_W),
      .DEPTH (wstm_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_head),
      .empty   (rsp_empty)
   );

   assign {rsp_result_kind, rsp_match_line, rsp_match_column, rsp_occurrence_count} = res_head;

endmodule
